// File: sv/oli_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Widths, request and response codes, and the control word that the list
// controller sends along the row of storage cells.
// ----------------------------------------------------------------------------
package oli_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int KIND_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int OCC_W          = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_DUMP   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_APPEND,
        OP_CAPTURE,
        OP_DELETE,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// File: sv/oli_req_if.sv
// ----------------------------------------------------------------------------
// Ordered list request channel
// Valid/ready channel carrying one list request.
// ----------------------------------------------------------------------------
interface oli_req_if
    import oli_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// File: sv/oli_rsp_if.sv
// ----------------------------------------------------------------------------
// Ordered list response channel
// Valid/ready channel carrying one list response.
// ----------------------------------------------------------------------------
interface oli_rsp_if
    import oli_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  entry;
    logic [OCC_W-1:0]          occupancy;
    logic                      last;

    modport source (output valid, output status, output entry, output occupancy,
                    output last, input ready);
    modport sink   (input valid, input status, input entry, input occupancy,
                    input last, output ready);
endinterface

// File: sv/oli_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry; appends, compares, closes a gap from its neighbour
// or rotates towards the head as the controller commands.
// ----------------------------------------------------------------------------
module oli_cell
    import oli_pkg::*;
#(
    parameter int  LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int  INDEX      = 0,
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctrl_t                ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic signed [DATA_W-1:0]  next_entry,
    input  logic signed [DATA_W-1:0]  head_entry,
    input  logic                      hit_in,
    output logic                      hit_out,
    output logic signed [DATA_W-1:0]  entry
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] ONE    = CNT_W'(1);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     match_reg;
    logic                     match_next;

    assign hit_out = hit_in | match_reg;
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        unique case (ctrl.op)
            OP_APPEND:
            begin
                if (count == MY_IDX)
                begin
                    entry_next = ctrl.value;
                end
            end
            OP_CAPTURE:
            begin
                match_next = (entry_reg == ctrl.value) && (MY_IDX < count);
            end
            OP_DELETE:
            begin
                if (hit_out)
                begin
                    entry_next = next_entry;
                end
                match_next = 1'b0;
            end
            OP_ROTATE:
            begin
                entry_next = (MY_IDX == count - ONE) ? head_entry : next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

// File: sv/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Ordered list with append, remove and dump
// Bounded list of signed 32-bit values held in a row of storage cells.
// ----------------------------------------------------------------------------
// An append request stores its value at the tail, or is answered as full.
// A remove request first has every cell compare its entry with the value,
// and then the first equal entry is dropped and the cells behind it each
// take their neighbour's entry. A dump of n entries gives n responses, one
// a cycle, as the row rotates towards the head and returns to its order; it
// is paced by the response channel. One request is handled at a time, and a
// new request is taken no earlier than the cycle in which the last response
// of the previous one is collected.
module ordered_list_insert_delete
    import oli_pkg::*;
#(
    parameter int  LIST_DEPTH = LIST_DEPTH_DEF,
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1)
)
(
    input  logic      clk,
    input  logic      rst_n,
    oli_req_if.sink   req,
    oli_rsp_if.source rsp
);

    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DUMP   = 3'b100
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         idx_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic [STATUS_W-1:0]      rsp_status_reg;
    logic [STATUS_W-1:0]      rsp_status_next;
    logic signed [DATA_W-1:0] rsp_entry_reg;
    logic signed [DATA_W-1:0] rsp_entry_next;
    logic [OCC_W-1:0]         rsp_occ_reg;
    logic [OCC_W-1:0]         rsp_occ_next;
    logic                     rsp_last_reg;
    logic                     rsp_last_next;

    cell_ctrl_t               ctrl;
    logic                     out_free;
    logic                     accept;
    logic                     found;
    logic                     hit [LIST_DEPTH+1];
    logic signed [DATA_W-1:0] cell_entry [LIST_DEPTH];

    assign hit[0] = 1'b0;
    assign found  = hit[LIST_DEPTH];

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        oli_cell #(
            .LIST_DEPTH (LIST_DEPTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (count_reg),
            .next_entry (cell_entry[(i + 1) % LIST_DEPTH]),
            .head_entry (cell_entry[0]),
            .hit_in     (hit[i]),
            .hit_out    (hit[i+1]),
            .entry      (cell_entry[i])
        );
    end

    assign out_free      = !rsp_valid_reg || rsp.ready;
    assign req.ready     = (state_reg == S_IDLE) && out_free;
    assign accept        = req.valid && req.ready;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.entry     = rsp_entry_reg;
    assign rsp.occupancy = rsp_occ_reg;
    assign rsp.last      = rsp_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        ctrl.op         = OP_HOLD;
        ctrl.value      = req.value;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_entry_next  = rsp_entry_reg;
        rsp_occ_next    = rsp_occ_reg;
        rsp_last_next   = rsp_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_entry_next = '0;
                    rsp_last_next  = 1'b1;
                    rsp_occ_next   = OCC_W'(count_reg);
                    case (kind_t'(req.kind))
                        KIND_APPEND:
                        begin
                            rsp_valid_next = 1'b1;
                            if (count_reg == FULL)
                            begin
                                rsp_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op         = OP_APPEND;
                                count_next      = count_reg + ONE;
                                rsp_status_next = STATUS_OK;
                                rsp_occ_next    = OCC_W'(count_reg + ONE);
                            end
                        end
                        KIND_REMOVE:
                        begin
                            ctrl.op    = OP_CAPTURE;
                            state_next = S_SEARCH;
                        end
                        KIND_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                ctrl.op        = OP_DELETE;
                rsp_valid_next = 1'b1;
                rsp_entry_next = '0;
                rsp_last_next  = 1'b1;
                if (found)
                begin
                    count_next      = count_reg - ONE;
                    rsp_status_next = STATUS_OK;
                    rsp_occ_next    = OCC_W'(count_reg - ONE);
                end
                else
                begin
                    rsp_status_next = STATUS_NOT_FOUND;
                    rsp_occ_next    = OCC_W'(count_reg);
                end
                state_next = S_IDLE;
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    ctrl.op         = OP_ROTATE;
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = STATUS_OK;
                    rsp_entry_next  = cell_entry[0];
                    rsp_occ_next    = OCC_W'(count_reg);
                    rsp_last_next   = (idx_reg == count_reg - ONE);
                    idx_next        = idx_reg + ONE;
                    if (idx_reg == count_reg - ONE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg <= rsp_status_next;
        rsp_entry_reg  <= rsp_entry_next;
        rsp_occ_reg    <= rsp_occ_next;
        rsp_last_reg   <= rsp_last_next;
    end

endmodule
